/* design/scalc_pkg.sv */
// Shared types and constants for the set-associative cache controller.
// No dependencies.
`timescale 1ns / 1ps
package scalc_pkg;

  localparam int AGE_W     = 4;
  localparam int SET_OUT_W = 17;
  localparam int WAY_OUT_W = 4;
  localparam int MAX_COUNT = 8;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  typedef enum logic [1:0] {
    CFG_WRITE_POLICY = 2'd0,
    CFG_WAYS_LOG2    = 2'd1,
    CFG_BURST_LOG2   = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] POL_WRITE_BACK = 2'd0;

  // Geometry derived from the configuration registers.
  typedef struct packed {
    logic [1:0] policy;
    logic [2:0] wl;
    logic [2:0] bbits;
    logic [4:0] sb;
  } geom_t;

  typedef struct packed {
    logic [SET_OUT_W-1:0] set_index;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 cache_updated;
    logic                 victim_valid;
    logic                 victim_writeback;
    logic                 fill_from_memory;
    logic                 write_through;
    logic                 last;
  } res_t;

endpackage

/* design/set_assoc_cache_lru_controller.sv */
// Set-associative cache controller, true LRU, selectable write policy.
// Each line an access touches goes through set read, lookup and update on the
// single set RAM in the back end before the next line is read; an access covers
// 1..5 lines. The front queue holds 4. After reset the set RAM is swept, one set
// per cycle (2^floor(log2 MAX_SETS) sets, 131072 by default) with s_axis_tready_o
// low; config writes still land.
`timescale 1ns / 1ps
module set_assoc_cache_lru_controller #(
  parameter int CACHE_BYTES = 262144,
  parameter int MAX_SETS    = 131072,
  parameter int MAX_WAYS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // address[31:0], byte_count[35:32]
  input  logic        s_axis_tuser_i,  // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // set_index[16:0], hit, way_used[21:18], cache_updated, victim_valid,
  // victim_writeback, fill_from_memory, write_through[26]
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [2:0]  cfg_data_i
);

  localparam int LOG_CB    = $clog2(CACHE_BYTES + 1) - 1;
  localparam int LOG_MS    = $clog2(MAX_SETS + 1) - 1;
  localparam int LOG_MW    = $clog2(MAX_WAYS + 1) - 1;
  localparam int WLMAX     = (LOG_MW > 4) ? 4 : LOG_MW;
  localparam int SHIFT_MIN = (LOG_CB - WLMAX < LOG_MS + 1) ? LOG_CB - WLMAX : LOG_MS + 1;
  localparam int TAG_W     = 32 - SHIFT_MIN;
  localparam int SET_W     = LOG_MS;
  localparam int OP_W      = TAG_W + SET_W + 2;

  logic [1:0] policy_q;
  logic [2:0] ways_q;
  logic [1:0] burst_q;

  scalc_pkg::geom_t geom;
  logic [5:0]       sb_diff;
  logic             init_done, q_full, q_empty, push, pop;
  logic [OP_W-1:0]  op_in, op_out;
  scalc_pkg::res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= '0;
      ways_q   <= '0;
      burst_q  <= '0;
    end else if (cfg_we_i) begin
      case (scalc_pkg::cfg_idx_e'(cfg_addr_i))
        scalc_pkg::CFG_WRITE_POLICY: policy_q <= cfg_data_i[1:0];
        scalc_pkg::CFG_WAYS_LOG2:    ways_q   <= cfg_data_i;
        scalc_pkg::CFG_BURST_LOG2:   burst_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign geom.policy = policy_q;
  assign geom.wl     = (ways_q > 3'(WLMAX)) ? 3'(WLMAX) : ways_q;
  assign geom.bbits  = {1'b0, burst_q} + 3'd1;
  assign sb_diff     = 6'(LOG_CB) - {3'b000, geom.wl} - {3'b000, geom.bbits};
  assign geom.sb     = (sb_diff > 6'(LOG_MS)) ? 5'(LOG_MS) : sb_diff[4:0];

  scalc_front #(
    .SET_W (SET_W),
    .TAG_W (TAG_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .geom_i          (geom),
    .init_done_i     (init_done),
    .full_i          (q_full),
    .push_o          (push),
    .op_o            (op_in)
  );

  scalc_queue #(
    .WIDTH (OP_W),
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (op_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (op_out),
    .empty_o (q_empty)
  );

  scalc_back #(
    .SET_W (SET_W),
    .TAG_W (TAG_W),
    .WLMAX (WLMAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .empty_i     (q_empty),
    .op_i        (op_out),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i),
    .init_done_o (init_done)
  );

  assign m_axis_tdata_o = {5'b00000, res.write_through, res.fill_from_memory,
                           res.victim_writeback, res.victim_valid, res.cache_updated,
                           res.way_used, res.hit, res.set_index};
  assign m_axis_tlast_o = res.last;

endmodule

/* design/scalc_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module scalc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/scalc_front.sv */
// Front end: accepts access beats and splits them into per-line operations.
// Depends on scalc_pkg.
`timescale 1ns / 1ps
module scalc_front #(
  parameter int SET_W = 17,
  parameter int TAG_W = 18
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [39:0]              s_axis_tdata_i,
  input  logic                     s_axis_tuser_i,
  input  scalc_pkg::geom_t         geom_i,
  input  logic                     init_done_i,
  input  logic                     full_i,
  output logic                     push_o,
  output logic [TAG_W+SET_W+1:0]   op_o
);

  logic        busy_q, wr_q;
  logic [31:0] blk_q;
  logic [2:0]  left_q;

  logic [31:0] addr;
  logic [3:0]  cnt;
  logic [4:0]  bmask, off, span, nm1;
  logic        accept;
  logic [31:0] line_addr, tag_full;
  logic [4:0]  shamt;
  logic [SET_W:0]   one_sh;
  logic [SET_W-1:0] set_mask, set_idx;
  logic        is_last;

  assign addr   = s_axis_tdata_i[31:0];
  assign cnt    = (s_axis_tdata_i[35:32] > 4'(scalc_pkg::MAX_COUNT)) ?
                  4'(scalc_pkg::MAX_COUNT) : s_axis_tdata_i[35:32];
  assign bmask  = (5'd1 << geom_i.bbits) - 5'd1;
  assign off    = addr[4:0] & bmask;
  assign span   = off + {1'b0, cnt} - 5'd1;
  assign nm1    = span >> geom_i.bbits;

  assign s_axis_tready_o = !busy_q && init_done_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign line_addr = blk_q << geom_i.bbits;
  assign shamt     = {2'b00, geom_i.bbits} + geom_i.sb;
  assign tag_full  = line_addr >> shamt;
  assign one_sh    = (SET_W+1)'(1) << geom_i.sb;
  assign set_mask  = SET_W'(one_sh - (SET_W+1)'(1));
  assign set_idx   = blk_q[SET_W-1:0] & set_mask;
  assign is_last   = (left_q == 3'd0);

  assign push_o = busy_q && !full_i;
  assign op_o   = {wr_q, is_last, set_idx, tag_full[TAG_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      wr_q   <= 1'b0;
      blk_q  <= '0;
      left_q <= '0;
    end else if (accept) begin
      if (cnt != 4'd0) begin
        busy_q <= 1'b1;
        wr_q   <= s_axis_tuser_i;
        blk_q  <= addr >> geom_i.bbits;
        left_q <= nm1[2:0];
      end
    end else if (push_o) begin
      blk_q  <= blk_q + 32'd1;
      left_q <= left_q - 3'd1;
      if (is_last) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

/* design/scalc_queue.sv */
// Small FIFO decoupling the front end from the back end.
// No dependencies.
`timescale 1ns / 1ps
module scalc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i && !full_o) - CW'(pop_i && !empty_o);
    end
  end

endmodule

/* design/scalc_back.sv */
// Back end: per-line tag lookup, LRU victim choice and set update.
// Depends on scalc_pkg and scalc_ram.
`timescale 1ns / 1ps
module scalc_back #(
  parameter int SET_W = 17,
  parameter int TAG_W = 18,
  parameter int WLMAX = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scalc_pkg::geom_t       geom_i,
  input  logic                   empty_i,
  input  logic [TAG_W+SET_W+1:0] op_i,
  output logic                   pop_o,
  output logic                   res_valid_o,
  output scalc_pkg::res_t        res_o,
  input  logic                   res_ready_i,
  output logic                   init_done_o
);

  localparam int NW    = 1 << WLMAX;
  localparam int AW    = scalc_pkg::AGE_W;
  localparam int WAY_W = TAG_W + 2 + AW;
  localparam int ROW_W = NW * WAY_W;
  localparam int WI_W  = (WLMAX > 0) ? WLMAX : 1;

  typedef enum logic [1:0] {B_CLR, B_IDLE, B_LOOK, B_UPD} state_e;

  state_e           state_q;
  logic [SET_W-1:0] clr_q;
  logic             wr_q, last_q, hit_q, byp_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [WI_W-1:0]  way_q;
  logic [ROW_W-1:0] row_q;
  logic             out_valid_q;
  scalc_pkg::res_t  out_q;

  logic             ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata, rdata, init_row, new_row;

  logic [4:0]       ways_n;
  logic [NW-1:0]    inuse;
  logic             hit_c;
  logic [WI_W-1:0]  hit_way, vic_way;
  logic [AW-1:0]    best;
  logic [WAY_W-1:0] sel_old;
  logic [AW-1:0]    age_w, age_i;
  logic             no_alloc, upd_go;

  assign ways_n   = 5'd1 << geom_i.wl;
  assign no_alloc = geom_i.policy[1];

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      inuse[i] = (5'(i) < ways_n);
    end
  end

  always_comb begin
    init_row = '0;
    for (int i = 0; i < NW; i++) begin
      init_row[i*WAY_W +: AW] = AW'(i);
    end
  end

  // lookup on the row just read
  always_comb begin
    hit_c   = 1'b0;
    hit_way = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (inuse[i] && rdata[i*WAY_W + AW + 1] &&
          rdata[i*WAY_W + AW + 2 +: TAG_W] == tag_q) begin
        hit_c   = 1'b1;
        hit_way = WI_W'(i);
      end
    end
    best    = rdata[AW-1:0];
    vic_way = '0;
    for (int i = 1; i < NW; i++) begin
      if (inuse[i] && rdata[i*WAY_W +: AW] > best) begin
        best    = rdata[i*WAY_W +: AW];
        vic_way = WI_W'(i);
      end
    end
  end

  // row update for the chosen way
  always_comb begin
    sel_old = row_q[way_q*WAY_W +: WAY_W];
    age_w   = sel_old[AW-1:0];
    new_row = row_q;
    for (int i = 0; i < NW; i++) begin
      age_i = row_q[i*WAY_W +: AW];
      if (inuse[i] && age_i < age_w && age_i != scalc_pkg::AGE_MAX) begin
        new_row[i*WAY_W +: AW] = age_i + AW'(1);
      end
    end
    new_row[way_q*WAY_W +: AW] = '0;
    if (!hit_q) begin
      new_row[way_q*WAY_W + AW + 2 +: TAG_W] = tag_q;
      new_row[way_q*WAY_W + AW + 1]          = 1'b1;
      new_row[way_q*WAY_W + AW]              = 1'b0;
    end
    if (wr_q && geom_i.policy == scalc_pkg::POL_WRITE_BACK) begin
      new_row[way_q*WAY_W + AW] = 1'b1;
    end
  end

  assign upd_go = (state_q == B_UPD) && (!out_valid_q || res_ready_i);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_q;
    ram_wdata = new_row;
    if (state_q == B_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = init_row;
    end else if (upd_go && !byp_q) begin
      ram_we = 1'b1;
    end
  end

  assign pop_o  = (state_q == B_IDLE) && !empty_i;
  assign ram_re = pop_o;

  scalc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (1 << SET_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (op_i[TAG_W +: SET_W]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      wr_q        <= 1'b0;
      last_q      <= 1'b0;
      hit_q       <= 1'b0;
      byp_q       <= 1'b0;
      set_q       <= '0;
      tag_q       <= '0;
      way_q       <= '0;
      row_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_CLR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == '1) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty_i) begin
            wr_q    <= op_i[TAG_W+SET_W+1];
            last_q  <= op_i[TAG_W+SET_W];
            set_q   <= op_i[TAG_W +: SET_W];
            tag_q   <= op_i[TAG_W-1:0];
            state_q <= B_LOOK;
          end
        end
        B_LOOK: begin
          row_q   <= rdata;
          hit_q   <= hit_c;
          way_q   <= hit_c ? hit_way : vic_way;
          byp_q   <= !hit_c && wr_q && no_alloc;
          state_q <= B_UPD;
        end
        B_UPD: begin
          if (upd_go) begin
            out_valid_q            <= 1'b1;
            out_q.set_index        <= scalc_pkg::SET_OUT_W'(set_q);
            out_q.hit              <= hit_q;
            out_q.way_used         <= byp_q ? '0 : scalc_pkg::WAY_OUT_W'(way_q);
            out_q.cache_updated    <= !byp_q;
            out_q.victim_valid     <= !hit_q && !byp_q && sel_old[AW+1];
            out_q.victim_writeback <= !hit_q && !byp_q && sel_old[AW+1] && sel_old[AW];
            out_q.fill_from_memory <= !hit_q && !byp_q;
            out_q.write_through    <= wr_q && (geom_i.policy != scalc_pkg::POL_WRITE_BACK);
            out_q.last             <= last_q;
            state_q                <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;
  assign init_done_o = (state_q != B_CLR);

endmodule

/* design/scalc_chk.sv */
// Port-level checker for the cache controller, bound to the top level.
// Depends on set_assoc_cache_lru_controller.
`timescale 1ns / 1ps
module scalc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        cfg_we_i,
  input logic [1:0]  cfg_addr_i,
  input logic [2:0]  cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result beat dropped or changed under stall");

  a_sweep_blocks_input: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready_o)
    else $error("input taken during set sweep");

  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[17] |->
      m_axis_tdata_o[22] && !m_axis_tdata_o[23] && !m_axis_tdata_o[25])
    else $error("hit reported with fill or victim");

  a_fill_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[25] == (!m_axis_tdata_o[17] && m_axis_tdata_o[22]))
    else $error("fill flag inconsistent with hit and allocation");

endmodule

bind set_assoc_cache_lru_controller scalc_chk u_chk (.*);
